@@ src/dsps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsps_pkg
// Shared types, codes and coil mapping for the dual stepper phase sequencer.
// ----------------------------------------------------------------------------
package dsps_pkg;

   // defaults for the top level parameters
   localparam int LAP_FRACTION_BITS_DEF = 8;
   localparam int STEP_COUNT_WIDTH_DEF  = 24;

   // field widths
   localparam int OP_W       = 2;
   localparam int LAPS_W     = 16;
   localparam int SPEED_W    = 10;
   localparam int CFG_W      = 16;
   localparam int PERIOD_W   = 16;
   localparam int MAG_W      = LAPS_W + 1;
   localparam int PROD_W     = MAG_W + CFG_W;
   localparam int DIV_CNT_W  = $clog2(PERIOD_W);
   localparam int COIL_W     = 8;
   localparam int REQ_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP = 2'd2;

   // register indexes
   localparam logic [1:0] REG_EXC_MODE  = 2'd0;
   localparam logic [1:0] REG_SPR       = 2'd1;
   localparam logic [1:0] REG_STEP_TIME = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] SPR_RESET       = 16'd2048;
   localparam logic [CFG_W-1:0] STEP_TIME_RESET = 16'd29297;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_EXEC
   } seq_state_type;

   typedef struct packed {
      logic capture;
      logic mul_load;
      logic div_step;
      logic commit;
   } seq_cmd_type;

   typedef struct packed {
      logic req_move;
      logic div_last;
      logic rsp_free;
   } seq_status_type;

   function automatic logic [3:0] rev4(input logic [3:0] r);
      rev4 = {r[0], r[1], r[2], r[3]};
   endfunction

   // one-coil or two-coil row of a phase, mapped to both motors
   function automatic logic [COIL_W-1:0] coil_map(input logic       mode,
                                                  input logic [1:0] phase,
                                                  input logic       spin,
                                                  input logic       back);
      logic [3:0] row;
      logic [3:0] a;
      logic [3:0] b;
      row = 4'b0001 << phase;
      if (mode) begin
         row = row | (4'b0001 << (phase + 2'd1));
      end
      if (spin) begin
         a = back ? rev4(row) : row;
         b = a;
      end else if (back) begin
         a = row;
         b = rev4(row);
      end else begin
         a = rev4(row);
         b = row;
      end
      coil_map = {b, a};
   endfunction

endpackage

@@ src/dsps_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsps_div
// Restoring divider for the step period, one quotient bit per cycle while step is high.
// ----------------------------------------------------------------------------
module dsps_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              init,
   input  logic                              step,
   input  logic [dsps_pkg::PERIOD_W-1:0]     dividend,
   input  logic [dsps_pkg::SPEED_W-1:0]      divisor,
   output logic [dsps_pkg::PERIOD_W-1:0]     quotient,
   output logic                              last
);

   logic [dsps_pkg::SPEED_W-1:0]   rem_ff;
   logic [dsps_pkg::SPEED_W-1:0]   rem_in;
   logic [dsps_pkg::PERIOD_W-1:0]  quo_ff;
   logic [dsps_pkg::PERIOD_W-1:0]  quo_in;
   logic [dsps_pkg::SPEED_W-1:0]   dsr_ff;
   logic [dsps_pkg::SPEED_W-1:0]   dsr_in;
   logic [dsps_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [dsps_pkg::DIV_CNT_W-1:0] cnt_in;
   logic [dsps_pkg::SPEED_W:0]     trial;
   logic                           ge;

   assign trial = {rem_ff, quo_ff[dsps_pkg::PERIOD_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (init) begin
         rem_in = '0;
         quo_in = dividend;
         // zero speed runs as the slowest speed
         dsr_in = (divisor == '0) ? dsps_pkg::SPEED_W'(1) : divisor;
         cnt_in = '0;
      end else if (step) begin
         rem_in = ge ? dsps_pkg::SPEED_W'(trial - {1'b0, dsr_ff})
                     : trial[dsps_pkg::SPEED_W-1:0];
         quo_in = {quo_ff[dsps_pkg::PERIOD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign last     = (cnt_ff == {dsps_pkg::DIV_CNT_W{1'b1}});

endmodule

@@ src/dsps_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsps_datapath
// Registers, move set-up arithmetic, tick stepping and the result register.
// ----------------------------------------------------------------------------
module dsps_datapath #(
   parameter int LAP_FRACTION_BITS = dsps_pkg::LAP_FRACTION_BITS_DEF,
   parameter int STEP_COUNT_WIDTH  = dsps_pkg::STEP_COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dsps_pkg::seq_cmd_type               cmd,
   output dsps_pkg::seq_status_type            status,
   input  logic [dsps_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [dsps_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dsps_pkg::COIL_W-1:0]         rsp_tdata,
   output logic [2:0]                          rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dsps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dsps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dsps_pkg::CSR_DATA_W-1:0]     csr_prdata
);

   localparam int W = STEP_COUNT_WIDTH;

   // configuration registers
   logic                         mode_ff;
   logic [dsps_pkg::CFG_W-1:0]   spr_ff;
   logic [dsps_pkg::CFG_W-1:0]   stime_ff;
   logic                         csr_wr;
   logic [1:0]                   csr_idx;

   // captured word
   logic [dsps_pkg::OP_W-1:0]    op_ff;
   logic                         motion_ff;
   logic [dsps_pkg::LAPS_W-1:0]  laps_ff;
   logic [dsps_pkg::SPEED_W-1:0] speed_ff;

   // move set-up
   logic [dsps_pkg::MAG_W-1:0]    mag;
   logic [dsps_pkg::PROD_W-1:0]   prod_ff;
   logic [dsps_pkg::PROD_W-1:0]   prod_in;
   logic [dsps_pkg::PROD_W-1:0]   prod_shift;
   logic [dsps_pkg::PROD_W-1:0]   sat_max;
   logic [W-1:0]                  tgt;
   logic [dsps_pkg::PERIOD_W-1:0] quotient;
   logic                          div_last;

   // sequencer state
   logic [dsps_pkg::COIL_W-1:0]   coil_ff,   coil_in;
   logic                          moving_ff, moving_in;
   logic                          spin_ff,   spin_in;
   logic                          back_ff,   back_in;
   logic [W-1:0]                  taken_ff,  taken_in;
   logic [W-1:0]                  target_ff, target_in;
   logic [dsps_pkg::PERIOD_W-1:0] cd_ff,     cd_in;
   logic [dsps_pkg::PERIOD_W-1:0] reload_ff, reload_in;
   logic [dsps_pkg::PERIOD_W-1:0] cd_dec;
   logic [W-1:0]                  taken_inc;
   logic                          stepped;
   logic                          finished;

   // result register
   logic                          rvalid_ff, rvalid_in;
   logic [dsps_pkg::COIL_W-1:0]   rcoil_ff;
   logic [2:0]                    rflags_ff;

   // ---------------- configuration port ----------------
   assign csr_idx = csr_paddr[3:2];
   assign csr_wr  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         spr_ff   <= dsps_pkg::SPR_RESET;
         stime_ff <= dsps_pkg::STEP_TIME_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            dsps_pkg::REG_EXC_MODE:  mode_ff  <= csr_pwdata[0];
            dsps_pkg::REG_SPR:       spr_ff   <= csr_pwdata[dsps_pkg::CFG_W-1:0];
            dsps_pkg::REG_STEP_TIME: stime_ff <= csr_pwdata[dsps_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         dsps_pkg::REG_EXC_MODE:  csr_prdata = dsps_pkg::CSR_DATA_W'(mode_ff);
         dsps_pkg::REG_SPR:       csr_prdata = dsps_pkg::CSR_DATA_W'(spr_ff);
         dsps_pkg::REG_STEP_TIME: csr_prdata = dsps_pkg::CSR_DATA_W'(stime_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // ---------------- capture and set-up ----------------
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_tuser;
         motion_ff <= req_tdata[0];
         laps_ff   <= req_tdata[dsps_pkg::LAPS_W:1];
         speed_ff  <= req_tdata[dsps_pkg::LAPS_W+dsps_pkg::SPEED_W:dsps_pkg::LAPS_W+1];
      end
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
      end
   end

   // magnitude of the signed lap count
   assign mag = laps_ff[dsps_pkg::LAPS_W-1]
              ? dsps_pkg::MAG_W'((1 << dsps_pkg::LAPS_W) - {1'b0, laps_ff})
              : {1'b0, laps_ff};
   assign prod_in = dsps_pkg::PROD_W'(mag) * dsps_pkg::PROD_W'(spr_ff);

   // target saturates one below all ones so the step count never wraps
   assign prod_shift = prod_ff >> LAP_FRACTION_BITS;
   assign sat_max    = dsps_pkg::PROD_W'({{(W-1){1'b1}}, 1'b0});
   assign tgt        = (prod_shift > sat_max) ? W'(sat_max) : W'(prod_shift);

   dsps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .init     (cmd.mul_load),
      .step     (cmd.div_step),
      .dividend (stime_ff),
      .divisor  (speed_ff),
      .quotient (quotient),
      .last     (div_last)
   );

   // ---------------- sequencer update ----------------
   assign cd_dec    = (cd_ff != '0) ? cd_ff - 1'b1 : '0;
   assign taken_inc = taken_ff + 1'b1;

   always_comb begin
      coil_in   = coil_ff;
      moving_in = moving_ff;
      spin_in   = spin_ff;
      back_in   = back_ff;
      taken_in  = taken_ff;
      target_in = target_ff;
      cd_in     = cd_ff;
      reload_in = reload_ff;
      stepped   = 1'b0;
      finished  = 1'b0;
      case (op_ff)
         dsps_pkg::OP_MOVE: begin
            spin_in   = motion_ff;
            back_in   = laps_ff[dsps_pkg::LAPS_W-1];
            target_in = tgt;
            reload_in = quotient;
            taken_in  = W'(1);
            coil_in   = dsps_pkg::coil_map(mode_ff, 2'd1, motion_ff,
                                           laps_ff[dsps_pkg::LAPS_W-1]);
            cd_in     = quotient;
            moving_in = 1'b1;
            stepped   = 1'b1;
         end
         dsps_pkg::OP_STOP: begin
            coil_in   = '0;
            moving_in = 1'b0;
            cd_in     = '0;
         end
         dsps_pkg::OP_TICK: begin
            if (moving_ff) begin
               cd_in = cd_dec;
               if (cd_dec == '0) begin
                  if (taken_ff <= target_ff) begin
                     taken_in = taken_inc;
                     coil_in  = dsps_pkg::coil_map(mode_ff, taken_inc[1:0], spin_ff, back_ff);
                     cd_in    = reload_ff;
                     stepped  = 1'b1;
                  end else begin
                     moving_in = 1'b0;
                     finished  = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coil_ff   <= '0;
         moving_ff <= 1'b0;
         spin_ff   <= 1'b0;
         back_ff   <= 1'b0;
         taken_ff  <= '0;
         target_ff <= '0;
         cd_ff     <= '0;
         reload_ff <= '0;
      end else if (cmd.commit) begin
         coil_ff   <= coil_in;
         moving_ff <= moving_in;
         spin_ff   <= spin_in;
         back_ff   <= back_in;
         taken_ff  <= taken_in;
         target_ff <= target_in;
         cd_ff     <= cd_in;
         reload_ff <= reload_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rvalid_in = rvalid_ff;
      if (rsp_tready) begin
         rvalid_in = 1'b0;
      end
      if (cmd.commit) begin
         rvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= rvalid_in;
      end
      if (cmd.commit) begin
         rcoil_ff  <= coil_in;
         rflags_ff <= {finished, stepped, moving_in};
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rcoil_ff;
   assign rsp_tuser  = rflags_ff;

   assign status.req_move = (req_tuser == dsps_pkg::OP_MOVE);
   assign status.div_last = div_last;
   assign status.rsp_free = ~rvalid_ff | rsp_tready;

endmodule

@@ src/dsps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsps_ctrl
// Controller: takes one word, runs move set-up for a move word, then commits the update.
// ----------------------------------------------------------------------------
module dsps_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  dsps_pkg::seq_status_type  status,
   output dsps_pkg::seq_cmd_type     cmd
);

   dsps_pkg::seq_state_type state_ff;
   dsps_pkg::seq_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dsps_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.req_move ? dsps_pkg::ST_MUL : dsps_pkg::ST_EXEC;
            end
         end
         dsps_pkg::ST_MUL: begin
            state_in = dsps_pkg::ST_DIV;
         end
         dsps_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = dsps_pkg::ST_EXEC;
            end
         end
         dsps_pkg::ST_EXEC: begin
            if (status.rsp_free) begin
               state_in = dsps_pkg::ST_IDLE;
            end
         end
         default: state_in = dsps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         dsps_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         dsps_pkg::ST_MUL: begin
            cmd.mul_load = 1'b1;
         end
         dsps_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         dsps_pkg::ST_EXEC: begin
            // hold the update until the result register can take it
            cmd.commit = status.rsp_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/dual_stepper_phase_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stepper_phase_sequencer_unit
// Flow: a tick or stop word goes from capture straight to its commit; a move
//   word first passes the multiply state and the bit-serial period divider.
// Hand-off: a new word is taken only once the last one has been committed; a
//   result waiting in the output register holds the commit until it is taken.
// Reset: synchronous; coils off, no move, registers at their reset values.
// ----------------------------------------------------------------------------
module dual_stepper_phase_sequencer_unit #(
   parameter int LAP_FRACTION_BITS = dsps_pkg::LAP_FRACTION_BITS_DEF,
   parameter int STEP_COUNT_WIDTH  = dsps_pkg::STEP_COUNT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dsps_pkg::REQ_DATA_W-1:0]  req_tdata,   // motion, laps_q8, speed_rpm
   input  logic [dsps_pkg::OP_W-1:0]        req_tuser,   // operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dsps_pkg::COIL_W-1:0]      rsp_tdata,   // coil_lines
   output logic [2:0]                       rsp_tuser,   // busy_res, stepped, finished
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dsps_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dsps_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dsps_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   dsps_pkg::seq_cmd_type    cmd;
   dsps_pkg::seq_status_type status;

   assign csr_pready = 1'b1;

   dsps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dsps_datapath #(
      .LAP_FRACTION_BITS (LAP_FRACTION_BITS),
      .STEP_COUNT_WIDTH  (STEP_COUNT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule
